/* rtl/core/triangle_scanline_span_macros.svh */
// Assertion macros for the triangle scanline span block.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef TRIANGLE_SCANLINE_SPAN_MACROS_SVH
`define TRIANGLE_SCANLINE_SPAN_MACROS_SVH

// Same-cycle implication, checked outside reset
`define TSS_ASSERT_IMPLIES(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define TSS_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

/* rtl/core/tss_pkg.sv */
// Package for the triangle scanline span block: widths, payload types,
// register codes and the edge setup function. No dependencies.
package tss_pkg;

  localparam int COORD_BITS   = 16;
  localparam int SCREEN_BITS  = 12;
  localparam int CFG_BITS     = 13;
  localparam int CFG_IDX_BITS = 2;
  localparam int EXT_BITS     = ((COORD_BITS > SCREEN_BITS) ? COORD_BITS : SCREEN_BITS) + 2;
  localparam int X_BITS       = COORD_BITS + 2;
  localparam int SETUP_LAT    = 2;
  localparam int DIV_LAT      = COORD_BITS + 2;

  localparam logic [CFG_BITS-1:0] WIDTH_RESET  = CFG_BITS'(640);
  localparam logic [CFG_BITS-1:0] HEIGHT_RESET = CFG_BITS'(480);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by;
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic        [SCREEN_BITS-1:0] row;
  } in_item_t;

  typedef struct packed {
    logic                   span_valid;
    logic [SCREEN_BITS-1:0] span_start;
    logic [SCREEN_BITS-1:0] span_end;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } vtx_t;

  // One crossing: x0 + (a * b) / c as sign plus magnitudes
  typedef struct packed {
    logic                         neg;
    logic        [COORD_BITS-1:0] am;
    logic        [COORD_BITS-1:0] bm;
    logic        [COORD_BITS-1:0] cm;
    logic signed [COORD_BITS-1:0] x0;
  } edge_t;

  function automatic edge_t make_edge(vtx_t p0, vtx_t p1, logic signed [EXT_BITS-1:0] y);
    logic signed [EXT_BITS-1:0]   a;
    logic signed [EXT_BITS-1:0]   am_w;
    logic signed [COORD_BITS:0]   b;
    logic signed [COORD_BITS:0]   c;
    logic signed [COORD_BITS:0]   bm_w;
    logic signed [COORD_BITS:0]   cm_w;
    edge_t e;
    a    = y - EXT_BITS'(p0.y);
    b    = (COORD_BITS+1)'(p1.x) - (COORD_BITS+1)'(p0.x);
    c    = (COORD_BITS+1)'(p1.y) - (COORD_BITS+1)'(p0.y);
    am_w = a[EXT_BITS-1] ? -a : a;
    bm_w = b[COORD_BITS] ? -b : b;
    cm_w = c[COORD_BITS] ? -c : c;
    e.neg = a[EXT_BITS-1] ^ b[COORD_BITS] ^ c[COORD_BITS];
    e.am  = am_w[COORD_BITS-1:0];
    e.bm  = bm_w[COORD_BITS-1:0];
    e.cm  = cm_w[COORD_BITS-1:0];
    e.x0  = p0.x;
    return e;
  endfunction

endpackage

/* rtl/core/tss_setup.sv */
// Setup stages: sort vertices by y, then check the row and build both edges.
// Depends on tss_pkg.
module tss_setup (
  input  logic                           clk_i,
  input  logic                           adv_i,
  input  tss_pkg::in_item_t              item_i,
  input  logic [tss_pkg::CFG_BITS-1:0]   width_i,
  input  logic [tss_pkg::CFG_BITS-1:0]   height_i,
  output tss_pkg::edge_t                 short_o,
  output tss_pkg::edge_t                 long_o,
  output logic                           row_ok_o
);

  localparam int EW = tss_pkg::EXT_BITS;

  tss_pkg::vtx_t v1, v2, v3, t1, t2, t3, u1, u2, u3;
  tss_pkg::vtx_t s1_d, s2_d, s3_d, s1_q, s2_q, s3_q;
  logic [tss_pkg::SCREEN_BITS-1:0] row_q;

  // Sort by y; tied vertices need not keep their input order
  always_comb begin
    v1 = '{x: item_i.ax, y: item_i.ay};
    v2 = '{x: item_i.bx, y: item_i.by};
    v3 = '{x: item_i.cx, y: item_i.cy};
    t1 = (v1.y > v2.y) ? v2 : v1;
    t2 = (v1.y > v2.y) ? v1 : v2;
    t3 = v3;
    u1 = (t1.y > t3.y) ? t3 : t1;
    u3 = (t1.y > t3.y) ? t1 : t3;
    u2 = t2;
    s1_d = u1;
    s2_d = (u2.y > u3.y) ? u3 : u2;
    s3_d = (u2.y > u3.y) ? u2 : u3;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_q  <= s1_d;
      s2_q  <= s2_d;
      s3_q  <= s3_d;
      row_q <= item_i.row;
    end
  end

  logic signed [EW-1:0] ye, y1e, y2e, y3e;
  logic           row_ok_d;
  tss_pkg::edge_t short_d, long_d;

  // Row range check and edge selection
  always_comb begin
    ye  = $signed(EW'(row_q));
    y1e = EW'(s1_q.y);
    y2e = EW'(s2_q.y);
    y3e = EW'(s3_q.y);
    row_ok_d = (ye >= y1e) && (ye <= y3e) &&
               (EW'(row_q) < EW'(height_i)) && (width_i != '0);
    short_d = (ye < y2e) ? tss_pkg::make_edge(s1_q, s2_q, ye)
                         : tss_pkg::make_edge(s2_q, s3_q, ye);
    long_d  = tss_pkg::make_edge(s1_q, s3_q, ye);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      short_o  <= short_d;
      long_o   <= long_d;
      row_ok_o <= row_ok_d;
    end
  end

endmodule

/* rtl/core/tss_div.sv */
// Crossing unit: one multiply stage, one restoring divide stage per quotient
// bit, then sign and offset. Depends on tss_pkg.
module tss_div (
  input  logic                              clk_i,
  input  logic                              adv_i,
  input  tss_pkg::edge_t                    edge_i,
  output logic signed [tss_pkg::X_BITS-1:0] x_o
);

  localparam int CB = tss_pkg::COORD_BITS;
  localparam int XB = tss_pkg::X_BITS;

  logic [2*CB-1:0]       prod_q;
  logic [CB-1:0]         dvs0_q;
  logic                  neg0_q;
  logic signed [CB-1:0]  x00_q;

  // Multiply magnitudes
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_q <= (2*CB)'(edge_i.am) * (2*CB)'(edge_i.bm);
      dvs0_q <= edge_i.cm;
      neg0_q <= edge_i.neg;
      x00_q  <= edge_i.x0;
    end
  end

  logic [CB-1:0]        rem_q [CB];
  logic [CB-1:0]        low_q [CB];
  logic [CB-1:0]        quo_q [CB];
  logic [CB-1:0]        dvs_q [CB];
  logic                 neg_q [CB];
  logic signed [CB-1:0] x0_q  [CB];

  // One quotient bit per stage
  for (genvar k = 0; k < CB; k++) begin : g_stage
    logic [CB-1:0]        rem_in, low_in, quo_in, dvs_in;
    logic                 neg_in;
    logic signed [CB-1:0] x0_in;
    logic [CB:0]          trial, diff;
    logic                 ge;

    if (k == 0) begin : g_first
      assign rem_in = prod_q[2*CB-1:CB];
      assign low_in = prod_q[CB-1:0];
      assign quo_in = '0;
      assign dvs_in = dvs0_q;
      assign neg_in = neg0_q;
      assign x0_in  = x00_q;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign low_in = low_q[k-1];
      assign quo_in = quo_q[k-1];
      assign dvs_in = dvs_q[k-1];
      assign neg_in = neg_q[k-1];
      assign x0_in  = x0_q[k-1];
    end

    assign trial = {rem_in, low_in[CB-1]};
    assign diff  = trial - {1'b0, dvs_in};
    assign ge    = (trial >= {1'b0, dvs_in});

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[k] <= ge ? diff[CB-1:0] : trial[CB-1:0];
        low_q[k] <= {low_in[CB-2:0], 1'b0};
        quo_q[k] <= {quo_in[CB-2:0], ge};
        dvs_q[k] <= dvs_in;
        neg_q[k] <= neg_in;
        x0_q[k]  <= x0_in;
      end
    end
  end

  logic signed [XB-1:0] qx, sq;

  // Apply sign, flat edge gives zero, add upper x
  always_comb begin
    qx = $signed(XB'(quo_q[CB-1]));
    if (dvs_q[CB-1] == '0) begin
      sq = '0;
    end else begin
      sq = neg_q[CB-1] ? -qx : qx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      x_o <= XB'(x0_q[CB-1]) + sq;
    end
  end

endmodule

/* rtl/core/tss_span.sv */
// Output stage: order the crossings, clip to the image and register the
// result transaction. Depends on tss_pkg.
module tss_span (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              adv_i,
  input  logic                              vld_i,
  input  logic                              row_ok_i,
  input  logic signed [tss_pkg::X_BITS-1:0] xs_i,
  input  logic signed [tss_pkg::X_BITS-1:0] xe_i,
  input  logic [tss_pkg::CFG_BITS-1:0]      width_i,
  output logic                              vld_o,
  output tss_pkg::out_item_t                item_o
);

  localparam int SB  = tss_pkg::SCREEN_BITS;
  localparam int XB  = tss_pkg::X_BITS;
  localparam int LW  = (tss_pkg::CFG_BITS > SB + 1) ? tss_pkg::CFG_BITS : SB + 1;
  localparam int CW  = ((XB > LW) ? XB : LW) + 1;
  localparam int LIM = 1 << SB;

  logic [LW-1:0]        weff;
  logic signed [CW-1:0] lo, hi, wc, st, en;
  logic                 ok;
  tss_pkg::out_item_t   item_d;

  always_comb begin
    // Clamp width to the screen range
    weff = (LW'(width_i) > LW'(LIM)) ? LW'(LIM) : LW'(width_i);
    wc   = $signed(CW'(weff));
    lo   = (xs_i > xe_i) ? CW'(xe_i) : CW'(xs_i);
    hi   = (xs_i > xe_i) ? CW'(xs_i) : CW'(xe_i);
    ok   = row_ok_i && (hi >= 0) && (lo < wc);
    st   = (lo < 0) ? '0 : lo;
    en   = (hi > wc - 1) ? wc - 1 : hi;
    item_d = '0;
    if (ok) begin
      item_d.span_valid = 1'b1;
      item_d.span_start = st[SB-1:0];
      item_d.span_end   = en[SB-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (adv_i) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      item_o <= item_d;
    end
  end

endmodule

/* rtl/core/triangle_scanline_span.sv */
// Triangle scanline span: top level with configuration registers and pipeline control.
// Depends on tss_pkg, tss_setup, tss_div, tss_span and the macro header.
//
// One row query per cycle is accepted while the pipeline is not held, and
// each gives one span transaction after passing two setup stages,
// a multiply stage, one restoring divide stage per coordinate bit, an offset
// stage and the output register. The whole pipeline holds while the output
// register is full and stalled, so in_stall_o follows out_stall_i then.
// Configuration writes are always ready and are registered before use.
`include "triangle_scanline_span_macros.svh"

module triangle_scanline_span (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  tss_pkg::in_item_t                   in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output tss_pkg::out_item_t                  out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [tss_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [tss_pkg::CFG_BITS-1:0]        cfg_data_i
);

  localparam int VL = tss_pkg::SETUP_LAT + tss_pkg::DIV_LAT;
  localparam int DL = tss_pkg::DIV_LAT;

  logic [tss_pkg::CFG_BITS-1:0] width_q, height_q;
  logic                         adv;

  assign cfg_ready_o = 1'b1;

  // Decode configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= tss_pkg::WIDTH_RESET;
      height_q <= tss_pkg::HEIGHT_RESET;
    end else if (cfg_valid_i) begin
      unique case (tss_pkg::cfg_reg_e'(cfg_index_i))
        tss_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        tss_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Advance unless the output holds a stalled transaction
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  logic vld_q [VL];
  logic ok_q  [DL];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < VL; i++) vld_q[i] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= in_valid_i;
      for (int i = 1; i < VL; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  tss_pkg::edge_t short_e, long_e;
  logic           row_ok;

  tss_setup u_setup (
    .clk_i    (clk_i),
    .adv_i    (adv),
    .item_i   (in_data_i),
    .width_i  (width_q),
    .height_i (height_q),
    .short_o  (short_e),
    .long_o   (long_e),
    .row_ok_o (row_ok)
  );

  // Carry the row check alongside the crossing units
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ok_q[0] <= row_ok;
      for (int i = 1; i < DL; i++) ok_q[i] <= ok_q[i-1];
    end
  end

  logic signed [tss_pkg::X_BITS-1:0] xs, xe;

  tss_div u_div_short (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .edge_i (short_e),
    .x_o    (xs)
  );

  tss_div u_div_long (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .edge_i (long_e),
    .x_o    (xe)
  );

  tss_span u_span (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .vld_i    (vld_q[VL-1]),
    .row_ok_i (ok_q[DL-1]),
    .xs_i     (xs),
    .xe_i     (xe),
    .width_i  (width_q),
    .vld_o    (out_valid_o),
    .item_o   (out_data_o)
  );

  `TSS_ASSERT_IMPLIES(a_invalid_zero, out_valid_o && !out_data_o.span_valid, (out_data_o.span_start == '0) && (out_data_o.span_end == '0), "invalid span not zero")
  `TSS_ASSERT_IMPLIES(a_span_order, out_valid_o && out_data_o.span_valid, out_data_o.span_start <= out_data_o.span_end, "span start after end")
  `TSS_ASSERT_NEXT(a_drain, out_valid_o && !out_stall_i && !vld_q[VL-1], !out_valid_o, "output transaction repeated")

endmodule
